>>> hdl/bfm_pkg.sv
package bfm_pkg;

    // Fixed field and register widths
    localparam int CFG_W  = 13;    // configuration register width
    localparam int DIM_W  = 15;    // clamped width, holds up to 32767
    localparam int H_W    = 13;    // clamped height, holds up to 4096
    localparam int ROW_W  = 12;    // row counter
    localparam int CHAN_W = 8;     // one color channel
    localparam int PAIR_W = 9;     // sum of two channel samples
    localparam int LANES  = 4;     // bytes per pixel
    localparam int LINE_W = LANES * PAIR_W;

    localparam int MAX_HEIGHT = 4096;

    // Register select on paddr[2]
    localparam logic REG_SRC_WIDTH  = 1'b0;
    localparam logic REG_SRC_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] SRC_WIDTH_RESET  = 13'd1024;
    localparam logic [CFG_W-1:0] SRC_HEIGHT_RESET = 13'd1024;

    // Frame geometry derived from the configuration registers
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [H_W-1:0]   height;
        logic [DIM_W-1:0] col_end;
        logic [H_W-1:0]   row_end;
        logic             wide;
        logic             tall;
    } geo_t;

    // One item on its way from the front stage to the averaging stage
    typedef struct packed {
        logic [LANES-1:0][PAIR_W-1:0] pair;
        logic                         wide;
        logic                         tall;
        logic                         last;
    } stage_t;

endpackage

>>> hdl/bfm_if.sv
interface bfm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    output in_alpha, input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    input in_alpha, output ready);
endinterface

interface bfm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, output frame_last, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_alpha, input frame_last, output ready);
endinterface

>>> hdl/bfm_ram.sv
module bfm_ram #(
    parameter int WIDTH  = 36,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one read port, registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/bfm_cfg.sv
module bfm_cfg #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output bfm_pkg::geo_t       geo
);

    logic [bfm_pkg::CFG_W-1:0] src_width_reg;
    logic [bfm_pkg::CFG_W-1:0] src_width_next;
    logic [bfm_pkg::CFG_W-1:0] src_height_reg;
    logic [bfm_pkg::CFG_W-1:0] src_height_next;
    bfm_pkg::geo_t             geo_reg;
    bfm_pkg::geo_t             geo_next;
    logic                      wr_strobe;

    // Clamp the raw registers and derive the used area
    function automatic bfm_pkg::geo_t derive(input logic [bfm_pkg::CFG_W-1:0] raw_w,
                                             input logic [bfm_pkg::CFG_W-1:0] raw_h);
        bfm_pkg::geo_t          g;
        logic [bfm_pkg::DIM_W-1:0] wx;
        logic [bfm_pkg::DIM_W-1:0] hx;
        wx = bfm_pkg::DIM_W'(raw_w);
        hx = bfm_pkg::DIM_W'(raw_h);
        if (wx == '0)
            g.width = bfm_pkg::DIM_W'(1);
        else if (wx > bfm_pkg::DIM_W'(MAX_WIDTH))
            g.width = bfm_pkg::DIM_W'(MAX_WIDTH);
        else
            g.width = wx;
        if (hx == '0)
            g.height = bfm_pkg::H_W'(1);
        else if (hx > bfm_pkg::DIM_W'(bfm_pkg::MAX_HEIGHT))
            g.height = bfm_pkg::H_W'(bfm_pkg::MAX_HEIGHT);
        else
            g.height = hx[bfm_pkg::H_W-1:0];
        g.wide    = (g.width >= bfm_pkg::DIM_W'(2));
        g.tall    = (g.height >= bfm_pkg::H_W'(2));
        g.col_end = g.wide ? {g.width[bfm_pkg::DIM_W-1:1], 1'b0} : bfm_pkg::DIM_W'(1);
        g.row_end = g.tall ? {g.height[bfm_pkg::H_W-1:1], 1'b0} : bfm_pkg::H_W'(1);
        return g;
    endfunction

    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite && pready;
    assign geo       = geo_reg;

    // Register writes
    always_comb
    begin
        src_width_next  = src_width_reg;
        src_height_next = src_height_reg;
        if (wr_strobe)
        begin
            unique case (paddr[2])
                bfm_pkg::REG_SRC_WIDTH:  src_width_next  = pwdata[bfm_pkg::CFG_W-1:0];
                bfm_pkg::REG_SRC_HEIGHT: src_height_next = pwdata[bfm_pkg::CFG_W-1:0];
                default:                 src_width_next  = src_width_reg;
            endcase
        end
        geo_next = derive(src_width_next, src_height_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= bfm_pkg::SRC_WIDTH_RESET;
            src_height_reg <= bfm_pkg::SRC_HEIGHT_RESET;
            geo_reg        <= derive(bfm_pkg::SRC_WIDTH_RESET, bfm_pkg::SRC_HEIGHT_RESET);
        end
        else
        begin
            src_width_reg  <= src_width_next;
            src_height_reg <= src_height_next;
            geo_reg        <= geo_next;
        end
    end

    // Register reads
    always_comb
    begin
        unique case (paddr[2])
            bfm_pkg::REG_SRC_WIDTH:  prdata = 32'(src_width_reg);
            bfm_pkg::REG_SRC_HEIGHT: prdata = 32'(src_height_reg);
            default:                 prdata = '0;
        endcase
    end

endmodule

>>> hdl/bfm_front.sv
module bfm_front #(
    parameter int MAX_WIDTH = 4096,
    parameter int LINE_AW   = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bfm_pkg::geo_t               geo,
    bfm_in_if.sink                      pix_in,
    input  logic                        take_ready,
    output logic                        line_wr_en,
    output logic [LINE_AW-1:0]          line_wr_addr,
    output logic [bfm_pkg::LINE_W-1:0]  line_wr_data,
    output logic                        line_rd_en,
    output logic [LINE_AW-1:0]          line_rd_addr,
    output bfm_pkg::stage_t             item,
    output logic                        item_valid
);

    localparam int CNT_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

    logic [CNT_W-1:0]                 col_reg;
    logic [CNT_W-1:0]                 col_next;
    logic [bfm_pkg::ROW_W-1:0]        row_reg;
    logic [bfm_pkg::ROW_W-1:0]        row_next;
    logic [bfm_pkg::LANES-1:0][7:0]   held_reg;
    logic [bfm_pkg::LANES-1:0][7:0]   held_next;
    logic [bfm_pkg::LANES-1:0][7:0]   pix;
    logic [bfm_pkg::LANES-1:0][bfm_pkg::PAIR_W-1:0] pair;
    logic [bfm_pkg::DIM_W-1:0]        col_ext;
    logic [bfm_pkg::DIM_W-1:0]        col_inc;
    logic [bfm_pkg::H_W-1:0]          row_ext;
    logic [bfm_pkg::H_W-1:0]          row_inc;
    logic [CNT_W-1:0]                 idx_full;
    logic                             accept;
    logic                             in_area;
    logic                             even_col;
    logic                             have_pair;
    logic                             even_row;

    assign pix_in.ready = take_ready;
    assign accept       = pix_in.valid && take_ready;
    assign pix          = {pix_in.in_alpha, pix_in.in_blue, pix_in.in_green, pix_in.in_red};

    // Position of the incoming pixel against the used area
    assign col_ext   = bfm_pkg::DIM_W'(col_reg);
    assign col_inc   = col_ext + bfm_pkg::DIM_W'(1);
    assign row_ext   = bfm_pkg::H_W'(row_reg);
    assign row_inc   = row_ext + bfm_pkg::H_W'(1);
    assign in_area   = (col_ext < geo.col_end) && (row_ext < geo.row_end);
    assign even_col  = geo.wide && !col_reg[0];
    assign have_pair = in_area && !even_col;
    assign even_row  = geo.tall && !row_reg[0];

    // Horizontal pair sums
    always_comb
    begin
        for (int k = 0; k < bfm_pkg::LANES; k++)
        begin
            pair[k] = bfm_pkg::PAIR_W'(pix[k]) +
                      (geo.wide ? bfm_pkg::PAIR_W'(held_reg[k]) : '0);
        end
    end

    // Even rows park their pair sums in the line store, odd rows fetch them
    assign idx_full     = col_reg >> 1;
    assign line_wr_en   = accept && have_pair && even_row;
    assign line_wr_addr = idx_full[LINE_AW-1:0];
    assign line_wr_data = pair;
    assign line_rd_en   = accept && have_pair && !even_row && geo.tall;
    assign line_rd_addr = idx_full[LINE_AW-1:0];

    assign item_valid = accept && have_pair && !even_row;
    always_comb
    begin
        item.pair = pair;
        item.wide = geo.wide;
        item.tall = geo.tall;
        item.last = (col_ext == geo.col_end - bfm_pkg::DIM_W'(1)) &&
                    (row_ext == geo.row_end - bfm_pkg::H_W'(1));
    end

    // Raster position and held even-column pixel
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        held_next = held_reg;
        if (accept)
        begin
            if (in_area && even_col)
            begin
                held_next = pix;
            end
            if (col_inc >= geo.width)
            begin
                col_next = '0;
                row_next = (row_inc >= geo.height) ? '0 : row_inc[bfm_pkg::ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            held_reg <= held_next;
        end
    end

endmodule

>>> hdl/bfm_back.sv
module bfm_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bfm_pkg::stage_t            item,
    input  logic                       item_valid,
    input  logic [bfm_pkg::LINE_W-1:0] line_rd_data,
    output logic                       take_ready,
    bfm_out_if.source                  pix_out
);

    bfm_pkg::stage_t                 s1_reg;
    logic                            s1_valid_reg;
    logic                            out_valid_reg;
    logic [bfm_pkg::LANES-1:0][7:0]  out_reg;
    logic [bfm_pkg::LANES-1:0][7:0]  out_next;
    logic                            last_reg;
    logic                            out_load;
    logic [bfm_pkg::PAIR_W-1:0]      above [bfm_pkg::LANES];
    logic [bfm_pkg::PAIR_W:0]        sum   [bfm_pkg::LANES];
    logic [bfm_pkg::PAIR_W:0]        shifted [bfm_pkg::LANES];
    logic [1:0]                      shift;

    // Output register frees up when empty or taken; stage one follows it
    assign out_load   = !out_valid_reg || pix_out.ready;
    assign take_ready = !s1_valid_reg || out_load;

    // Add the pair sums of the row above and divide by the sample count
    assign shift = {1'b0, s1_reg.wide} + {1'b0, s1_reg.tall};
    always_comb
    begin
        for (int k = 0; k < bfm_pkg::LANES; k++)
        begin
            above[k]   = s1_reg.tall ? line_rd_data[k*bfm_pkg::PAIR_W +: bfm_pkg::PAIR_W] : '0;
            sum[k]     = {1'b0, s1_reg.pair[k]} + {1'b0, above[k]};
            shifted[k] = sum[k] >> shift;
            out_next[k] = shifted[k][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_ready)
        begin
            s1_reg <= item;
        end
        if (out_load)
        begin
            out_reg  <= out_next;
            last_reg <= s1_reg.last;
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.out_red    = out_reg[0];
    assign pix_out.out_green  = out_reg[1];
    assign pix_out.out_blue   = out_reg[2];
    assign pix_out.out_alpha  = out_reg[3];
    assign pix_out.frame_last = last_reg;

endmodule

>>> hdl/box_filter_mip_downsample_core.sv
// 2x2 box-filter mip downsampler for an RGBA8 raster stream. Source pixels
// enter one per clock on pix_in while pix_in is not held back; each output
// pixel on pix_out is the truncated per-channel mean of a 2x2 source block
// (2 samples when one source dimension is 1, 1 sample when both are), and
// frame_last marks the final output of a frame. An odd trailing column or row
// is taken in and dropped. Throughput is one item per clock when the output
// is not stalled, set by the line store, which takes one write (even rows) or
// one read (odd rows) per pixel pair. A result is registered first in the
// stage register, with the line store read at the edge that accepts its last
// source pixel, and then in the output register; with both registers full, a
// stalled output holds back pix_in. The line store holds MAX_WIDTH/2 entries
// of four 9-bit pair sums and needs no clearing after reset. src_width
// (address 0) and src_height (address 4) are to be written over APB only
// while the stream is idle; the block itself does not enforce this. The raster
// position is kept across such writes.
module box_filter_mip_downsample_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    bfm_in_if.sink      pix_in,
    bfm_out_if.source   pix_out
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    bfm_pkg::geo_t                geo;
    bfm_pkg::stage_t              item;
    logic                         item_valid;
    logic                         take_ready;
    logic                         line_wr_en;
    logic [LINE_AW-1:0]           line_wr_addr;
    logic [bfm_pkg::LINE_W-1:0]   line_wr_data;
    logic                         line_rd_en;
    logic [LINE_AW-1:0]           line_rd_addr;
    logic [bfm_pkg::LINE_W-1:0]   line_rd_data;

    // Configuration registers
    bfm_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geo     (geo)
    );

    // Position tracking, horizontal pairing, line store access
    bfm_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .LINE_AW   (LINE_AW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .geo          (geo),
        .pix_in       (pix_in),
        .take_ready   (take_ready),
        .line_wr_en   (line_wr_en),
        .line_wr_addr (line_wr_addr),
        .line_wr_data (line_wr_data),
        .line_rd_en   (line_rd_en),
        .line_rd_addr (line_rd_addr),
        .item         (item),
        .item_valid   (item_valid)
    );

    // Pair sums of the even rows
    bfm_ram #(
        .WIDTH  (bfm_pkg::LINE_W),
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (LINE_AW)
    ) u_line (
        .clk     (clk),
        .wr_en   (line_wr_en),
        .wr_addr (line_wr_addr),
        .wr_data (line_wr_data),
        .rd_en   (line_rd_en),
        .rd_addr (line_rd_addr),
        .rd_data (line_rd_data)
    );

    // Vertical add, divide, output register
    bfm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .line_rd_data (line_rd_data),
        .take_ready   (take_ready),
        .pix_out      (pix_out)
    );

endmodule
